@@ rtl/dtwsl_pkg.sv @@
// Package for the DDS tuning-word serial loader.
// Shared types and fixed constants; no dependencies.
`default_nettype none

package dtwsl_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

  localparam logic [31:0] REF_CLOCK_RST = 32'd180000000;
  localparam logic [31:0] MUL_THRESHOLD_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] OFFSET_RST = 32'd0;

  // Frequency datapath
  localparam int unsigned FREQ_W = 32;
  // ceil(2^34 / 6): f * DIV6_RECIP >> 34 equals f / 6 for any 32-bit f
  localparam logic [31:0] DIV6_RECIP = 32'hAAAA_AAAB;
  localparam int unsigned DIV6_SHIFT = 34;

  // Control byte that trails the tuning word
  localparam int unsigned CTRL_BITS = 8;
  localparam logic [CTRL_BITS-1:0] CTRL_MUL = 8'h09;
  localparam logic [CTRL_BITS-1:0] CTRL_NORMAL = 8'h00;

  localparam int unsigned IDX_W = 6;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              mul;
  } dtwsl_job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } dtwsl_div_state_e;

endpackage

`default_nettype wire

@@ rtl/dtwsl_front.sv @@
// Front end: offset subtraction, multiplier-mode decision and divide by six.
// Uses dtwsl_pkg.
`default_nettype none

module dtwsl_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [31:0]                 offset_hz_i,
  input  wire logic [31:0]                 mul_threshold_hz_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [dtwsl_pkg::FREQ_W-1:0] frequency_hz_i,
  input  wire logic                        apply_offset_i,
  output logic                             job_valid_o,
  input  wire logic                        job_ready_i,
  output dtwsl_pkg::dtwsl_job_t            job_o
);

  localparam int unsigned FW = dtwsl_pkg::FREQ_W;

  logic          s1_valid_q, s2_valid_q;
  logic [FW-1:0] s1_freq_q, s1_freq_d;
  logic [FW-1:0] s2_freq_q;
  logic          s2_mul_q;
  logic [FW-dtwsl_pkg::DIV6_SHIFT+FW-1:0] s2_quot_q;
  logic [2*FW-1:0] prod;
  logic [FW:0]   diff;
  logic          s2_free, s1_free, s1_move;

  assign s2_free = !s2_valid_q || job_ready_i;
  assign s1_move = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;

  // borrow of the subtraction, with the zero test, tells whether frequency exceeds the offset
  assign diff = {1'b0, frequency_hz_i} - {1'b0, offset_hz_i};
  always_comb begin
    s1_freq_d = frequency_hz_i;
    if (apply_offset_i && !diff[FW] && (diff[FW-1:0] != '0)) begin
      s1_freq_d = diff[FW-1:0];
    end
  end

  assign prod = s1_freq_q * dtwsl_pkg::DIV6_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_freq_q <= s1_freq_d;
    end
    if (s1_move) begin
      s2_freq_q <= s1_freq_q;
      s2_mul_q  <= s1_freq_q > mul_threshold_hz_i;
      s2_quot_q <= prod[2*FW-1:dtwsl_pkg::DIV6_SHIFT];
    end
  end

  assign job_valid_o = s2_valid_q;
  assign job_o.mul   = s2_mul_q;
  assign job_o.freq  = s2_mul_q ? FW'(s2_quot_q) : s2_freq_q;

endmodule

`default_nettype wire

@@ rtl/dtwsl_queue.sv @@
// Two-entry job queue between the front end and the divider.
// Uses dtwsl_pkg.
`default_nettype none

module dtwsl_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  dtwsl_pkg::dtwsl_job_t push_job_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output dtwsl_pkg::dtwsl_job_t pop_job_o
);

  dtwsl_pkg::dtwsl_job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dtwsl_div.sv @@
// Bit-serial restoring divider: floor(f * 2^WORD_BITS / ref_clock), saturated.
// Uses dtwsl_pkg.
`default_nettype none

module dtwsl_div #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [31:0]           ref_clock_hz_i,
  input  wire logic                  job_valid_i,
  output logic                       job_ready_o,
  input  dtwsl_pkg::dtwsl_job_t      job_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output logic [WORD_BITS-1:0]       res_word_o,
  output logic                       res_mul_o
);

  localparam int unsigned FW    = dtwsl_pkg::FREQ_W;
  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  dtwsl_pkg::dtwsl_div_state_e state_q, state_d;

  logic [CNT_W-1:0]     cnt_q;
  logic [FW-1:0]        rem_q;
  logic [WORD_BITS-1:0] quo_q;
  logic                 mul_q;
  logic [FW:0]          rem2;
  logic                 ge;
  logic                 sat;
  logic                 start;

  // f >= d means the quotient overflows the word; d == 0 lands here too
  assign sat   = job_i.freq >= ref_clock_hz_i;
  assign rem2  = {rem_q, 1'b0};
  assign ge    = rem2 >= {1'b0, ref_clock_hz_i};
  assign start = (state_q == dtwsl_pkg::DIV_IDLE) && job_valid_i;

  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      dtwsl_pkg::DIV_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          state_d = sat ? dtwsl_pkg::DIV_DONE : dtwsl_pkg::DIV_RUN;
        end
      end
      dtwsl_pkg::DIV_RUN: begin
        if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
          state_d = dtwsl_pkg::DIV_DONE;
        end
      end
      dtwsl_pkg::DIV_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = dtwsl_pkg::DIV_IDLE;
        end
      end
      default: state_d = dtwsl_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtwsl_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        cnt_q <= '0;
      end else if (state_q == dtwsl_pkg::DIV_RUN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q <= job_i.freq;
      quo_q <= sat ? '1 : '0;
      mul_q <= job_i.mul;
    end else if (state_q == dtwsl_pkg::DIV_RUN) begin
      rem_q <= ge ? FW'(rem2 - {1'b0, ref_clock_hz_i}) : FW'(rem2);
      quo_q <= {quo_q[WORD_BITS-2:0], ge};
    end
  end

  assign res_word_o = quo_q;
  assign res_mul_o  = mul_q;

endmodule

`default_nettype wire

@@ rtl/dtwsl_shift.sv @@
// Serializer: tuning word then control byte, LSB first, one bit per word out.
// Uses dtwsl_pkg.
`default_nettype none

module dtwsl_shift #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       res_valid_i,
  output logic                            res_ready_o,
  input  wire logic [WORD_BITS-1:0]       res_word_i,
  input  wire logic                       res_mul_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            serial_bit_o,
  output logic [dtwsl_pkg::IDX_W-1:0]     bit_index_o,
  output logic                            last_bit_o
);

  localparam int unsigned TOTAL = WORD_BITS + dtwsl_pkg::CTRL_BITS;
  localparam int unsigned IW    = dtwsl_pkg::IDX_W;

  logic             busy_q;
  logic [TOTAL-1:0] sreg_q;
  logic [IW-1:0]    idx_q;
  logic             last, take, load;

  assign last = idx_q == IW'(TOTAL - 1);
  assign take = busy_q && out_ready_i;
  // next job loads in the cycle its predecessor's final bit leaves
  assign res_ready_o = !busy_q || (take && last);
  assign load = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (take) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sreg_q <= {(res_mul_i ? dtwsl_pkg::CTRL_MUL : dtwsl_pkg::CTRL_NORMAL), res_word_i};
    end else if (take) begin
      sreg_q <= {1'b0, sreg_q[TOTAL-1:1]};
    end
  end

  assign out_valid_o  = busy_q;
  assign serial_bit_o = sreg_q[0];
  assign bit_index_o  = idx_q;
  assign last_bit_o   = last;

endmodule

`default_nettype wire

@@ rtl/dds_tuning_word_serial_load_unit.sv @@
// Top level of the DDS tuning-word serial loader: config registers and wiring.
// Uses dtwsl_pkg, dtwsl_front, dtwsl_queue, dtwsl_div, dtwsl_shift.
//
//   port group   direction  handshake                 payload
//   in           input      in_valid_i / in_ready_o   frequency_hz_i, apply_offset_i
//   out          output     out_valid_o / out_ready_i serial_bit_o, bit_index_o, last_bit_o
//   cfg          input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Each request yields WORD_BITS + 8 output words, one per cycle while out_ready_i
// is high; sustained throughput is set by the serializer. The divider runs
// under the previous request's shift-out. Reset is asynchronous and needs no
// clearing pass. Output stalls back up through the divider and a two-entry
// queue to in_ready_o.
`default_nettype none

module dds_tuning_word_serial_load_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dtwsl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dtwsl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [31:0]                      frequency_hz_i,
  input  wire logic                             apply_offset_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  serial_bit_o,
  output logic [5:0]                            bit_index_o,
  output logic                                  last_bit_o
);

  logic [31:0] ref_clock_q, mul_threshold_q, offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clock_q     <= dtwsl_pkg::REF_CLOCK_RST;
      mul_threshold_q <= dtwsl_pkg::MUL_THRESHOLD_RST;
      offset_q        <= dtwsl_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtwsl_pkg::REG_REF_CLOCK:     ref_clock_q     <= cfg_wdata_i;
        dtwsl_pkg::REG_MUL_THRESHOLD: mul_threshold_q <= cfg_wdata_i;
        dtwsl_pkg::REG_OFFSET:        offset_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dtwsl_pkg::dtwsl_job_t front_job, queue_job;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;
  logic res_valid, res_ready, res_mul;
  logic [WORD_BITS-1:0] res_word;

  dtwsl_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .offset_hz_i        (offset_q),
    .mul_threshold_hz_i (mul_threshold_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .frequency_hz_i     (frequency_hz_i),
    .apply_offset_i     (apply_offset_i),
    .job_valid_o        (front_valid),
    .job_ready_i        (front_ready),
    .job_o              (front_job)
  );

  dtwsl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_job_o    (queue_job)
  );

  dtwsl_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ref_clock_hz_i (ref_clock_q),
    .job_valid_i    (queue_valid),
    .job_ready_o    (queue_ready),
    .job_i          (queue_job),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_word_o     (res_word),
    .res_mul_o      (res_mul)
  );

  dtwsl_shift #(
    .WORD_BITS (WORD_BITS)
  ) u_shift (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_word_i   (res_word),
    .res_mul_i    (res_mul),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .serial_bit_o (serial_bit_o),
    .bit_index_o  (bit_index_o),
    .last_bit_o   (last_bit_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for dds_tuning_word_serial_load_unit: random and directed frequency requests,
// each checked against a predicted 40-bit serial word stream. Uses dtwsl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned N_BITS = WORD_W + dtwsl_pkg::CTRL_BITS;
  localparam int unsigned MUL_DIV = 6;
  localparam int unsigned WD_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_PRINTED = 50;
  // index past the register list, writes must be dropped
  localparam logic [dtwsl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    bit       serial;
    bit [5:0] idx;
    bit       last;
  } dds_bit_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  class serial_word_checker;
    bit [31:0] ref_clk;
    bit [31:0] mul_thr;
    bit [31:0] if_offset;
    dds_bit_t  pending_bits[$];
    int        n_errors;

    function new();
      ref_clk   = dtwsl_pkg::REF_CLOCK_RST;
      mul_thr   = dtwsl_pkg::MUL_THRESHOLD_RST;
      if_offset = dtwsl_pkg::OFFSET_RST;
      n_errors  = 0;
    endfunction

    function void set_reg(logic [dtwsl_pkg::CFG_IDX_W-1:0] idx, bit [31:0] data);
      case (idx)
        dtwsl_pkg::REG_REF_CLOCK:     ref_clk = data;
        dtwsl_pkg::REG_MUL_THRESHOLD: mul_thr = data;
        dtwsl_pkg::REG_OFFSET:        if_offset = data;
        default: ;
      endcase
    endfunction

    // floor(f * 2^32 / ref_clk), saturated; zero divisor saturates too
    function bit [31:0] calc_tuning_word(bit [31:0] f);
      bit [63:0] q;
      if (ref_clk == 0) return '1;
      q = {f, 32'h0} / {32'h0, ref_clk};
      if (q[63:32] != 0) return '1;
      return q[31:0];
    endfunction

    function void note_request(bit [31:0] freq, bit use_off);
      bit [31:0] f;
      bit        mul;
      bit [31:0] word;
      bit [7:0]  ctrl;
      dds_bit_t  b;
      f = freq;
      if (use_off && f > if_offset) f = f - if_offset;
      mul = f > mul_thr;
      if (mul) f = f / MUL_DIV;
      word = calc_tuning_word(f);
      ctrl = mul ? dtwsl_pkg::CTRL_MUL : dtwsl_pkg::CTRL_NORMAL;
      for (int k = 0; k < N_BITS; k++) begin
        if (k < WORD_W) b.serial = word[k];
        else b.serial = ctrl[k - WORD_W];
        b.idx  = k[5:0];
        b.last = (k == N_BITS - 1);
        pending_bits.push_back(b);
      end
    endfunction

    task report_mismatch(string msg);
      if (n_errors < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      n_errors++;
    endtask

    task check_bit(bit s, bit [5:0] idx, bit l);
      dds_bit_t e;
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected word idx=%0d bit=%0b last=%0b", idx, s, l));
        return;
      end
      e = pending_bits.pop_front();
      if (s != e.serial)
        report_mismatch($sformatf("serial_bit idx %0d: got %0b, want %0b", e.idx, s, e.serial));
      if (idx != e.idx)
        report_mismatch($sformatf("bit_index: got %0d, want %0d", idx, e.idx));
      if (l != e.last)
        report_mismatch($sformatf("last_bit idx %0d: got %0b, want %0b", e.idx, l, e.last));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [dtwsl_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [dtwsl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [31:0]                      freq = '0;
  logic                             apply_off = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             serial_bit;
  logic [5:0]                       bit_index;
  logic                             last_bit;

  serial_word_checker sb;
  rx_mode_e           rx_mode = RX_OPEN;
  int unsigned        rx_cnt = 0;
  int unsigned        quiet_cycles = 0;

  always #5 clk = ~clk;

  dds_tuning_word_serial_load_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .frequency_hz_i (freq),
    .apply_offset_i (apply_off),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .serial_bit_o   (serial_bit),
    .bit_index_o    (bit_index),
    .last_bit_o     (last_bit)
  );

  // receiver backpressure, pattern chosen at random from four modes
  always @(negedge clk) begin
    if (rx_cnt % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ready <= (rx_cnt % 5 != 0);
      default:     out_ready <= (rx_cnt % 16 >= 6);
    endcase
    rx_cnt++;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_bit(serial_bit, bit_index, last_bit);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("FAIL dds_tuning_word_serial_load_unit");
      $finish;
    end
  end

  task automatic drive_word(bit [31:0] f, bit o);
    @(negedge clk);
    in_valid  <= 1'b1;
    freq      <= f;
    apply_off <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(f, o);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk);
    in_valid  <= 1'b0;
    freq      <= $urandom;
    apply_off <= $urandom_range(0, 1);
    repeat (n) @(posedge clk);
  endtask

  task automatic stop_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [dtwsl_pkg::CFG_IDX_W-1:0] idx, bit [31:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  task automatic load_settings(bit [31:0] r, bit [31:0] t, bit [31:0] o);
    write_reg(dtwsl_pkg::REG_REF_CLOCK, r);
    write_reg(dtwsl_pkg::REG_MUL_THRESHOLD, t);
    write_reg(dtwsl_pkg::REG_OFFSET, o);
    close_writes();
  endtask

  task automatic wait_drained();
    while (sb.pending_bits.size() != 0) @(posedge clk);
  endtask

  // frequencies clustered around the decision points of the current settings
  function automatic bit [31:0] pick_freq();
    int unsigned jitter;
    jitter = $urandom_range(0, 4);
    case ($urandom_range(0, 8))
      0, 1:    return $urandom;
      2:       return sb.ref_clk + jitter - 2;
      3:       return sb.mul_thr + jitter - 2;
      4:       return sb.if_offset + jitter - 2;
      5:       return $urandom_range(0, 1000);
      6:       return sb.mul_thr + sb.if_offset + jitter - 2;
      7:       return sb.ref_clk * MUL_DIV + jitter - 2;
      default: return $urandom_range(0, 60000000);
    endcase
  endfunction

  task automatic run_requests(int unsigned n, bit no_gaps);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < n; j++) begin
        drive_word(pick_freq(), $urandom_range(0, 1));
        sent++;
      end
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) pause_sender(gap);
    end
    stop_sender();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes and exact saturation at the reference clock
    drive_word(32'd0, 1'b0);
    drive_word(32'hFFFF_FFFF, 1'b0);
    drive_word(32'hFFFF_FFFF, 1'b1);
    drive_word(32'd1, 1'b1);
    drive_word(32'd180000000, 1'b0);
    drive_word(32'd179999999, 1'b0);
    drive_word(32'd90000000, 1'b1);
    stop_sender();
    wait_drained();

    // offset and multiplier boundaries
    load_settings(32'd125000000, 32'd40000000, 32'd10700000);
    drive_word(32'd10700000, 1'b1);
    drive_word(32'd10700001, 1'b1);
    drive_word(32'd10699999, 1'b1);
    drive_word(32'd0, 1'b1);
    drive_word(32'd40000000, 1'b0);
    drive_word(32'd40000001, 1'b0);
    drive_word(32'd50700000, 1'b1);
    drive_word(32'd50700001, 1'b1);
    drive_word(32'd750000000, 1'b0);
    drive_word(32'd749999999, 1'b0);
    drive_word(32'hFFFF_FFFF, 1'b1);
    stop_sender();
    run_requests(30, 1'b0);
    wait_drained();

    // smallest divisor, every nonzero frequency in multiplier mode, offset never applies
    load_settings(32'd1, 32'd0, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, $urandom);
    close_writes();
    run_requests(20, 1'b0);
    wait_drained();

    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    run_requests(20, 1'b1);
    wait_drained();

    // zero reference clock saturates every word
    load_settings(32'd0, $urandom, $urandom_range(0, 1000000));
    run_requests(15, 1'b0);
    wait_drained();

    repeat (3) begin
      load_settings(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000000, 500000000),
                    ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(10000000, 200000000),
                    $urandom_range(0, 50000000));
      run_requests(20, 1'b0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending_bits.size() == 0)
      $display("PASS dds_tuning_word_serial_load_unit");
    else
      $display("FAIL dds_tuning_word_serial_load_unit");
    $finish;
  end

endmodule
